### rtl/apbm_pkg.sv
// Package for the ARGB pixel blender: mode codes, pixel masks and bytewise helpers.
// No dependencies.
`default_nettype none

package apbm_pkg;

   localparam int unsigned PIXEL_W = 32;
   localparam int unsigned SCALE_W = 8;
   localparam int unsigned MODE_W  = 4;
   localparam int unsigned REQ_W   = 2 * PIXEL_W + SCALE_W;

   localparam logic [PIXEL_W-1:0] ALPHA_MASK  = 32'hFF00_0000;
   localparam logic [PIXEL_W-1:0] COLOUR_MASK = 32'h00FF_FFFF;
   localparam logic [15:0]        ROUND_BIAS  = 16'h00FF;

   typedef enum logic [MODE_W-1:0] {
      MODE_XOR            = 4'd0,
      MODE_DIRECT_XOR     = 4'd1,
      MODE_OVERLAY        = 4'd2,
      MODE_ADDITIVE       = 4'd3,
      MODE_ADDITIVE_PAINT = 4'd4,
      MODE_REPLACE        = 4'd5,
      MODE_INVERT_DROP    = 4'd6,
      MODE_DROP           = 4'd7,
      MODE_REPLACE_ALPHA  = 4'd8,
      MODE_XOR_ALL        = 4'd9,
      MODE_INVERTED_DRAW  = 4'd10,
      MODE_PAINT          = 4'd11
   } mode_type;

   // per-byte unsigned add, clamped at 255
   function automatic logic [23:0] add_sat_colour(input logic [23:0] x, input logic [23:0] y);
      logic [23:0] r;
      logic [8:0]  s;
      r = '0;
      for (int i = 0; i < 3; i++) begin
         s = {1'b0, x[i*8 +: 8]} + {1'b0, y[i*8 +: 8]};
         r[i*8 +: 8] = s[8] ? 8'hFF : s[7:0];
      end
      return r;
   endfunction

   // per-byte subtract, wrapping mod 256
   function automatic logic [PIXEL_W-1:0] sub_wrap_bytes(input logic [PIXEL_W-1:0] x,
                                                         input logic [PIXEL_W-1:0] y);
      logic [PIXEL_W-1:0] r;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         r[i*8 +: 8] = x[i*8 +: 8] - y[i*8 +: 8];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/argb_pixel_blend_modes.sv
// ARGB8888 pixel blender, top level: three-stage pipeline from request stream to result.
// Depends on apbm_pkg.
//
// One blended pixel per clock while rsp_tready is high; an accepted item passes the
// stage one and two registers into the result register. Stage one registers the item
// with its 8x8 alpha product, stage two rounds it to the scaled alpha and, in XOR and
// additive modes, masks top with it and base with its inverse, stage three selects the
// mode's result. The whole pipeline, empty slots included, holds while a result waits on
// rsp_tready; req_tready is high whenever the result register is empty or being taken.
`default_nettype none

module argb_pixel_blend_modes (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   // top_pixel [31:0], base_pixel [63:32], alpha_scale [71:64]
   input  wire logic [apbm_pkg::REQ_W-1:0]    req_tdata,
   // mode [3:0]
   input  wire logic [apbm_pkg::MODE_W-1:0]   req_tuser,
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   // blended_pixel [31:0]
   output      logic [apbm_pkg::PIXEL_W-1:0]  rsp_tdata
);
   import apbm_pkg::*;

   logic advance;

   logic               s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0] s1_top_ff, s1_base_ff;
   logic [MODE_W-1:0]  s1_mode_ff;
   logic [15:0]        s1_prod_ff, s1_prod_in;

   logic               s2_valid_ff;
   logic [PIXEL_W-1:0] s2_top_ff, s2_top_in;
   logic [PIXEL_W-1:0] s2_base_ff, s2_base_in;
   logic [MODE_W-1:0]  s2_mode_ff;
   logic [7:0]         s2_sa_ff, s2_sa_in;
   logic [15:0]        s1_round;

   logic               s3_valid_ff;
   logic [PIXEL_W-1:0] s3_pix_ff, s3_pix_in;
   logic [PIXEL_W-1:0] s2_mask;

   assign advance    = !s3_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = s3_pix_ff;

   // stage 1: alpha product
   assign s1_valid_in = req_tvalid;
   assign s1_prod_in  = {8'h00, req_tdata[31:24]} * {8'h00, req_tdata[71:64]};

   // stage 2: scaled alpha and colour masking
   assign s1_round = s1_prod_ff + ROUND_BIAS;
   assign s2_sa_in = s1_round[15:8];

   always_comb begin
      s2_top_in  = s1_top_ff;
      s2_base_in = s1_base_ff;
      if (s1_mode_ff == MODE_XOR || s1_mode_ff == MODE_ADDITIVE) begin
         s2_top_in  = s1_top_ff & {8'h00, {3{s2_sa_in}}};
         s2_base_in = s1_base_ff & ~{8'h00, {3{s2_sa_in}}};
      end
   end

   // stage 3: mode select
   assign s2_mask = {8'h00, {3{s2_sa_ff}}};

   always_comb begin
      unique case (s2_mode_ff) inside
         MODE_XOR, MODE_DIRECT_XOR: begin
            s3_pix_in = s2_base_ff ^ (s2_top_ff & COLOUR_MASK);
         end
         MODE_OVERLAY: begin
            s3_pix_in = (s2_sa_ff != 8'd0)
                        ? ((s2_top_ff & COLOUR_MASK) | (s2_base_ff & ALPHA_MASK))
                        : s2_base_ff;
         end
         MODE_ADDITIVE, MODE_ADDITIVE_PAINT: begin
            s3_pix_in = {s2_base_ff[31:24], add_sat_colour(s2_top_ff[23:0], s2_base_ff[23:0])};
         end
         MODE_REPLACE: begin
            s3_pix_in = s2_top_ff;
         end
         MODE_INVERT_DROP: begin
            s3_pix_in = (s2_base_ff & COLOUR_MASK) | (~s2_top_ff & ALPHA_MASK);
         end
         MODE_DROP: begin
            s3_pix_in = (s2_base_ff & COLOUR_MASK) | (s2_top_ff & ALPHA_MASK);
         end
         MODE_REPLACE_ALPHA: begin
            s3_pix_in = {s2_sa_ff, s2_top_ff[23:0]};
         end
         MODE_XOR_ALL: begin
            s3_pix_in = s2_top_ff ^ s2_base_ff;
         end
         MODE_INVERTED_DRAW: begin
            s3_pix_in = sub_wrap_bytes(s2_base_ff, s2_mask);
         end
         MODE_PAINT: begin
            s3_pix_in = (s2_base_ff & ALPHA_MASK) | (s2_top_ff & COLOUR_MASK);
         end
         default: begin
            s3_pix_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_top_ff  <= req_tdata[31:0];
         s1_base_ff <= req_tdata[63:32];
         s1_mode_ff <= req_tuser;
         s1_prod_ff <= s1_prod_in;
         s2_top_ff  <= s2_top_in;
         s2_base_ff <= s2_base_in;
         s2_mode_ff <= s1_mode_ff;
         s2_sa_ff   <= s2_sa_in;
         s3_pix_ff  <= s3_pix_in;
      end
   end

`ifndef SYNTHESIS
   // a stall freezes every stage
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s1_valid_ff) && $stable(s2_valid_ff) && $stable(s2_sa_ff))
      else $error("pipeline moved during stall");

   // full scaled alpha needs full top alpha and full scale
   a_sa_full: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_round[15:8] == 8'hFF |-> s1_prod_ff == 16'hFE01)
      else $error("scaled alpha saturated from partial inputs");

   // undefined modes give zero
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      advance && s2_valid_ff && s2_mode_ff[3] && s2_mode_ff[2] |=> rsp_tdata == '0)
      else $error("undefined mode gave nonzero pixel");

   // an accepted item reaches stage one
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid_ff)
      else $error("accepted item lost at stage one");
`endif

endmodule

`default_nettype wire
